[rtl/rbsi_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package rbsi_pkg;
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS = 16;
  localparam int NUM_REGS = 6;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_MIN_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MIN_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MIN_Z = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MAX_X = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MAX_Y = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MAX_Z = 3'd5;
endpackage
`default_nettype wire

[rtl/rbsi_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// pipelined saturating signed fixed-point divider, one quotient bit per stage
module rbsi_div #(
  parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH,
  parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS,
  parameter int TAG_W = 1
) (
  input wire logic clk,
  input wire logic en,
  input wire logic signed [COORD_WIDTH:0] num,
  input wire logic signed [COORD_WIDTH-1:0] den,
  input wire logic [TAG_W-1:0] tag_in,
  output logic signed [COORD_WIDTH-1:0] quo,
  output logic [TAG_W-1:0] tag_out
);
  // numerator magnitude up to 2^CW, shifted by FRAC_BITS
  localparam int NW = COORD_WIDTH + 1 + FRAC_BITS;
  localparam int DW = COORD_WIDTH;
  localparam int QW = COORD_WIDTH - 1;
  localparam int ST = NW;
  localparam logic [QW-1:0] TMAX = {QW{1'b1}};

  logic [NW-1:0] n_s [ST+1];
  logic [DW:0] r_s [ST+1];
  logic [NW-1:0] q_s [ST+1];
  logic [DW-1:0] d_s [ST+1];
  logic neg_s [ST+1];
  logic [TAG_W-1:0] t_s [ST+1];

  logic [COORD_WIDTH:0] nmag;
  logic [COORD_WIDTH-1:0] dmag;
  assign nmag = num[COORD_WIDTH] ? (COORD_WIDTH+1)'(0) - num : num;
  assign dmag = den[COORD_WIDTH-1] ? COORD_WIDTH'(0) - den : den;

  always_comb begin
    n_s[0] = {nmag, {FRAC_BITS{1'b0}}};
    r_s[0] = '0;
    q_s[0] = '0;
    d_s[0] = dmag;
    neg_s[0] = num[COORD_WIDTH] ^ den[COORD_WIDTH-1];
    t_s[0] = tag_in;
  end

  // restoring division, one bit per stage, registered at each stage
  for (genvar g = 0; g < ST; g++) begin : g_st
    logic [DW+1:0] rs;
    logic ge;
    assign rs = {r_s[g], n_s[g][NW-1]};
    assign ge = rs >= {2'b00, d_s[g]};
    always_ff @(posedge clk) begin
      if (en) begin
        n_s[g+1] <= n_s[g] << 1;
        r_s[g+1] <= ge ? (DW+1)'(rs - {2'b00, d_s[g]}) : rs[DW:0];
        q_s[g+1] <= {q_s[g][NW-2:0], ge};
        d_s[g+1] <= d_s[g];
        neg_s[g+1] <= neg_s[g];
        t_s[g+1] <= t_s[g];
      end
    end
  end

  logic [QW-1:0] qsat;
  assign qsat = (q_s[ST] > NW'(TMAX)) ? TMAX : q_s[ST][QW-1:0];
  assign quo = neg_s[ST] ? COORD_WIDTH'(0) - {1'b0, qsat} : {1'b0, qsat};
  assign tag_out = t_s[ST];
endmodule
`default_nettype wire

[rtl/rbsi_slab.sv]
`timescale 1ns / 1ps
`default_nettype none
// one axis: two plane distances, ordered, plus parallel test
module rbsi_slab #(
  parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH,
  parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS
) (
  input wire logic clk,
  input wire logic en,
  input wire logic signed [COORD_WIDTH-1:0] orig,
  input wire logic signed [COORD_WIDTH-1:0] dir,
  input wire logic signed [COORD_WIDTH-1:0] bmin,
  input wire logic signed [COORD_WIDTH-1:0] bmax,
  output logic signed [COORD_WIDTH-1:0] t_lo,
  output logic signed [COORD_WIDTH-1:0] t_hi,
  output logic par,
  output logic par_ok
);
  logic signed [COORD_WIDTH:0] na, nb, ea;
  logic [1:0] tg_in, tg_a, tg_b;
  logic signed [COORD_WIDTH-1:0] qa, qb;
  assign ea = {orig[COORD_WIDTH-1], orig};
  assign na = {bmin[COORD_WIDTH-1], bmin} - ea;
  assign nb = {bmax[COORD_WIDTH-1], bmax} - ea;
  assign tg_in = {dir == '0, (orig >= bmin) && (orig <= bmax)};

  rbsi_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS), .TAG_W(2)) u_da (
    .clk(clk), .en(en), .num(na), .den(dir), .tag_in(tg_in),
    .quo(qa), .tag_out(tg_a));
  rbsi_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS), .TAG_W(2)) u_db (
    .clk(clk), .en(en), .num(nb), .den(dir), .tag_in(tg_in),
    .quo(qb), .tag_out(tg_b));

  always_ff @(posedge clk) begin
    if (en) begin
      t_lo <= (qa > qb) ? qb : qa;
      t_hi <= (qa > qb) ? qa : qb;
      par <= tg_a[1];
      par_ok <= tg_b[0];
    end
  end
endmodule
`default_nettype wire

[rtl/ray_box_slab_interval.sv]
`timescale 1ns / 1ps
`default_nettype none
// throughput: one request per cycle while the output register is not stalled
// the bit-serial divider pipelines of each axis set the depth
// stalls freeze the whole pipeline; output register holds the result until taken
// reset: synchronous, active high; clears valid bits and loads box to +/-0.5
module ray_box_slab_interval #(
  parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH,
  parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS
) (
  input wire logic clk,
  input wire logic rst,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z from lowest bit
  input wire logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input wire logic s_axis_tvalid,
  output logic s_axis_tready,
  // hit, t_near, t_far from lowest bit
  output logic [((2*COORD_WIDTH-1+7)/8)*8-1:0] m_axis_tdata,
  output logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic cfg_valid,
  output logic cfg_ready,
  input wire logic [rbsi_pkg::REG_IDX_W-1:0] cfg_index,
  input wire logic [COORD_WIDTH-1:0] cfg_data
);
  localparam int CW = COORD_WIDTH;
  localparam int QW = CW - 1;
  localparam int DEPTH = CW + 1 + FRAC_BITS + 2;
  localparam int OW = ((2*CW-1+7)/8)*8;
  localparam logic signed [CW-1:0] HALF =
    (FRAC_BITS == 0) ? CW'(0) : CW'(1) <<< (FRAC_BITS > 0 ? FRAC_BITS-1 : 0);
  localparam logic signed [CW-1:0] TMAX = {1'b0, {QW{1'b1}}};

  logic signed [CW-1:0] bmin [3];
  logic signed [CW-1:0] bmax [3];

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        bmin[i] <= -HALF;
        bmax[i] <= HALF;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        rbsi_pkg::REG_MIN_X: bmin[0] <= cfg_data;
        rbsi_pkg::REG_MIN_Y: bmin[1] <= cfg_data;
        rbsi_pkg::REG_MIN_Z: bmin[2] <= cfg_data;
        rbsi_pkg::REG_MAX_X: bmax[0] <= cfg_data;
        rbsi_pkg::REG_MAX_Y: bmax[1] <= cfg_data;
        rbsi_pkg::REG_MAX_Z: bmax[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipeline advances unless the output register is full and stalled
  logic en;
  logic [DEPTH-1:0] vld;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[DEPTH-2:0], s_axis_tvalid};
  end

  logic signed [CW-1:0] lo [3];
  logic signed [CW-1:0] hi [3];
  logic par [3];
  logic pok [3];

  for (genvar a = 0; a < 3; a++) begin : g_ax
    rbsi_slab #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_slab (
      .clk(clk), .en(en),
      .orig(s_axis_tdata[a*CW +: CW]), .dir(s_axis_tdata[(a+3)*CW +: CW]),
      .bmin(bmin[a]), .bmax(bmax[a]),
      .t_lo(lo[a]), .t_hi(hi[a]), .par(par[a]), .par_ok(pok[a]));
  end

  // interval reduction: a parallel axis leaves [lo,hi] alone but may miss
  logic signed [CW-1:0] al [3];
  logic signed [CW-1:0] ah [3];
  logic bad;
  always_comb begin
    bad = 1'b0;
    for (int i = 0; i < 3; i++) begin
      al[i] = par[i] ? CW'(0) : lo[i];
      ah[i] = par[i] ? TMAX : hi[i];
      if (par[i] && !pok[i]) bad = 1'b1;
    end
  end

  logic signed [CW-1:0] rlo, rhi;
  logic rbad;
  always_ff @(posedge clk) begin
    if (en) begin
      rlo <= (al[0] > al[1]) ? ((al[0] > al[2]) ? al[0] : al[2])
                             : ((al[1] > al[2]) ? al[1] : al[2]);
      rhi <= (ah[0] < ah[1]) ? ((ah[0] < ah[2]) ? ah[0] : ah[2])
                             : ((ah[1] < ah[2]) ? ah[1] : ah[2]);
      rbad <= bad;
    end
  end

  // closed interval starts at [0, TMAX]; max with 0 and hit test
  logic signed [CW-1:0] flo;
  logic fhit;
  assign flo = (rlo > 0) ? rlo : CW'(0);
  assign fhit = !rbad && (flo <= rhi) && (rhi >= 0);

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (en) m_axis_tvalid <= vld[DEPTH-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= OW'({fhit ? rhi[QW-1:0] : QW'(0),
                           fhit ? flo[QW-1:0] : QW'(0), fhit});
    end
  end

  // output must hold while stalled
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed under stall");
  // a miss always reports zero distances
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[2*CW-2:1] == '0)
    else $error("miss with nonzero distance");
  // ready only depends on output stall
  assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");
endmodule
`default_nettype wire

[tb/sv/tb_ray_box_slab_interval.sv]
`timescale 1ns / 1ps
module tb_ray_box_slab_interval;

  localparam int CW = rbsi_pkg::COORD_WIDTH;
  localparam int FB = rbsi_pkg::FRAC_BITS;
  localparam int IN_W = ((6*CW+7)/8)*8;
  localparam int OUT_W = ((2*CW-1+7)/8)*8;
  localparam longint TMAX = (64'sd1 <<< (CW-1)) - 1;
  localparam int LATENCY = CW + FB + 4;
  localparam int N_RANDOM = 2000;
  // quiet stretch at the end of the run
  localparam int N_QUIET = 200;

  typedef struct {
    logic [CW-1:0] ox, oy, oz, dx, dy, dz;
  } ray_t;

  typedef struct packed {
    logic hit;
    logic [CW-2:0] t_near;
    logic [CW-2:0] t_far;
  } slab_hit_t;

  // one directed request: ray, and optional typed-in answer
  typedef struct {
    ray_t r;
    bit known;
    slab_hit_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rbsi_pkg::REG_IDX_W-1:0] cfg_index = '0;
  logic [CW-1:0] cfg_data = '0;

  always #4 clk = ~clk;

  ray_box_slab_interval u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tdata(s_axis_tdata), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // box copy kept by the predictor
  longint box_lo [3];
  longint box_hi [3];

  slab_hit_t hits_pending [$];
  int n_fail = 0;
  bit rx_quiet = 1'b0;

  function automatic longint sx(logic [CW-1:0] v);
    return longint'(signed'(v));
  endfunction

  // exact signed quotient in fixed point, magnitude truncated then saturated
  function automatic longint slab_quot(longint num, longint den);
    logic [127:0] n, d, q;
    longint res;
    n = (num < 0) ? 128'(-num) : 128'(num);
    d = (den < 0) ? 128'(-den) : 128'(den);
    q = (n << FB) / d;
    res = (q > 128'(TMAX)) ? TMAX : longint'(q);
    return ((num < 0) != (den < 0)) ? -res : res;
  endfunction

  function automatic slab_hit_t predict_hit(ray_t r);
    longint o [3];
    longint d [3];
    longint lo, hi, a, b, t;
    bit ok;
    slab_hit_t res;
    o[0] = sx(r.ox); o[1] = sx(r.oy); o[2] = sx(r.oz);
    d[0] = sx(r.dx); d[1] = sx(r.dy); d[2] = sx(r.dz);
    lo = 0;
    hi = TMAX;
    ok = 1'b1;
    for (int ax = 0; ax < 3; ax++) begin
      if (!ok) continue;
      if (d[ax] == 0) begin
        ok = (o[ax] >= box_lo[ax]) && (o[ax] <= box_hi[ax]);
      end else begin
        a = slab_quot(box_lo[ax] - o[ax], d[ax]);
        b = slab_quot(box_hi[ax] - o[ax], d[ax]);
        if (a > b) begin
          t = a; a = b; b = t;
        end
        if (a > hi || b < lo) begin
          ok = 1'b0;
        end else begin
          if (a > lo) lo = a;
          if (b < hi) hi = b;
        end
      end
    end
    res.hit = ok;
    res.t_near = ok ? lo[CW-2:0] : '0;
    res.t_far = ok ? hi[CW-2:0] : '0;
    return res;
  endfunction

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return CW'(signed'($urandom_range(0, 2*65536*8)) - 65536*8);
      2: return '0;
      3: return {1'b0, {(CW-1){1'b1}}};
      4: return {1'b1, {(CW-1){1'b0}}};
      default: return CW'(signed'($urandom_range(0, 2*65536*64)) - 65536*64);
    endcase
  endfunction

  function automatic ray_t rand_ray();
    ray_t r;
    r.ox = rand_coord(); r.oy = rand_coord(); r.oz = rand_coord();
    r.dx = rand_coord(); r.dy = rand_coord(); r.dz = rand_coord();
    // aim most rays back at the box so hits are common
    if ($urandom_range(0, 2) != 0) begin
      r.dx = CW'(-sx(r.ox) / 4);
      r.dy = CW'(-sx(r.oy) / 4);
      r.dz = CW'(-sx(r.oz) / 4);
      if ($urandom_range(0, 3) == 0) r.dy = '0;
    end
    return r;
  endfunction

  task automatic write_box(logic [rbsi_pkg::REG_IDX_W-1:0] idx, logic [CW-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx < 3) box_lo[idx] = sx(val);
    else if (idx < rbsi_pkg::NUM_REGS) box_hi[idx-3] = sx(val);
    @(posedge clk);
  endtask

  // waits for the result stream to drain, plus pipeline depth
  task automatic drain_hits();
    while (hits_pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic set_box(logic [CW-1:0] lx, ly, lz, hx, hy, hz);
    drain_hits();
    write_box(rbsi_pkg::REG_MIN_X, lx);
    write_box(rbsi_pkg::REG_MIN_Y, ly);
    write_box(rbsi_pkg::REG_MIN_Z, lz);
    write_box(rbsi_pkg::REG_MAX_X, hx);
    write_box(rbsi_pkg::REG_MAX_Y, hy);
    write_box(rbsi_pkg::REG_MAX_Z, hz);
  endtask

  // send one request; expectation is queued at acceptance
  task automatic send_ray(ray_t r, bit known, slab_hit_t want, bit gaps);
    slab_hit_t p;
    if (gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_axis_tdata <= IN_W'({r.dz, r.dy, r.dx, r.oz, r.oy, r.ox});
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    p = predict_hit(r);
    if (known && p != want)
      $error("directed row disagrees with predictor: hit %0d t_near %0h t_far %0h",
             p.hit, p.t_near, p.t_far);
    hits_pending.push_back(known ? want : p);
  endtask

  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
  endtask

  // receiver: random back-pressure except in the final stretch
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else if (rx_quiet) m_axis_tready <= 1'b1;
    else if (!m_axis_tready) m_axis_tready <= ($urandom_range(0, 1) == 0);
    else m_axis_tready <= ($urandom_range(0, 4) != 0);
  end

  // result checker
  always @(posedge clk) begin
    slab_hit_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.hit = m_axis_tdata[0];
      got.t_near = m_axis_tdata[CW-1:1];
      got.t_far = m_axis_tdata[2*CW-2:CW];
      if (hits_pending.size() == 0) begin
        $error("result with nothing expected");
        n_fail++;
      end else begin
        want = hits_pending.pop_front();
        if (got.hit !== want.hit) begin
          $error("hit expected %0d actual %0d", want.hit, got.hit);
          n_fail++;
        end
        if (got.t_near !== want.t_near) begin
          $error("t_near expected %0h actual %0h", want.t_near, got.t_near);
          n_fail++;
        end
        if (got.t_far !== want.t_far) begin
          $error("t_far expected %0h actual %0h", want.t_far, got.t_far);
          n_fail++;
        end
      end
    end
  end

  localparam logic [CW-1:0] ONE = CW'(1) << FB;
  localparam logic [CW-1:0] HALF = CW'(1) << (FB-1);
  localparam logic [CW-1:0] MAXC = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MINC = {1'b1, {(CW-1){1'b0}}};
  localparam slab_hit_t MISS = '{1'b0, '0, '0};
  localparam slab_hit_t INSIDE = '{1'b1, '0, MAXC[CW-2:0]};

  dir_row_t dir_rows [18] = '{
    // all axes parallel, origin at centre of reset box
    '{'{'0, '0, '0, '0, '0, '0}, 1'b1, INSIDE},
    // all parallel, origin on the face: closed box
    '{'{HALF, '0, '0, '0, '0, '0}, 1'b1, INSIDE},
    '{'{-HALF, -HALF, -HALF, '0, '0, '0}, 1'b1, INSIDE},
    // all parallel, outside
    '{'{HALF + 1, '0, '0, '0, '0, '0}, 1'b1, MISS},
    '{'{MAXC, MAXC, MAXC, '0, '0, '0}, 1'b1, MISS},
    '{'{MINC, MINC, MINC, '0, '0, '0}, 1'b1, MISS},
    // unit ray along +x from -2: enters at 1.5, leaves at 2.5
    '{'{-(ONE*2), '0, '0, ONE, '0, '0}, 1'b1,
      '{1'b1, 31'(ONE + ONE + HALF - ONE), 31'(ONE*2 + HALF)}},
    // pointing away
    '{'{-(ONE*2), '0, '0, -ONE, '0, '0}, 1'b1, MISS},
    // extreme and ordinary directions and origins, predictor only
    '{'{MAXC, MAXC, MAXC, MINC, MINC, MINC}, 1'b0, MISS},
    '{'{MINC, MINC, MINC, MAXC, MAXC, MAXC}, 1'b0, MISS},
    '{'{'0, '0, '0, 1, 1, 1}, 1'b0, MISS},
    '{'{'0, '0, '0, MINC, 1, '1}, 1'b0, MISS},
    '{'{'1, '1, '1, '1, '1, '1}, 1'b0, MISS},
    '{'{-ONE, -ONE, -ONE, ONE, ONE, ONE}, 1'b0, MISS},
    '{'{-ONE, '0, ONE, ONE, '0, -ONE}, 1'b0, MISS},
    '{'{'0, -(ONE*3), '0, '0, ONE, '0}, 1'b0, MISS},
    '{'{'0, '0, ONE*5, '0, '0, -HALF}, 1'b0, MISS},
    '{'{HALF, HALF, -ONE, '0, '0, ONE}, 1'b0, MISS}
  };

  initial begin
    slab_hit_t none;
    ray_t r;
    none = MISS;
    box_lo = '{-longint'(HALF), -longint'(HALF), -longint'(HALF)};
    box_hi = '{longint'(HALF), longint'(HALF), longint'(HALF)};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // directed rows against the reset box
    foreach (dir_rows[i]) send_ray(dir_rows[i].r, dir_rows[i].known, dir_rows[i].want, 1'b1);
    end_burst();

    // inverted box and the full-range extremes, predictor checked
    set_box(HALF, HALF, HALF, -HALF, -HALF, -HALF);
    for (int i = 0; i < 6; i++) send_ray(dir_rows[i + 6].r, 1'b0, none, 1'b1);
    send_ray(dir_rows[0].r, 1'b1, MISS, 1'b1);
    end_burst();
    set_box(MINC, MINC, MINC, MAXC, MAXC, MAXC);
    foreach (dir_rows[i]) send_ray(dir_rows[i].r, 1'b0, none, 1'b1);
    end_burst();
    // out-of-range index must be ignored
    drain_hits();
    write_box(3'd7, '0);

    // random phases, each with a new box
    for (int ph = 0; ph < 8; ph++) begin
      logic [CW-1:0] lo3 [3];
      logic [CW-1:0] hi3 [3];
      for (int a = 0; a < 3; a++) begin
        lo3[a] = CW'(-longint'($urandom_range(0, 8*65536)));
        hi3[a] = CW'(longint'($urandom_range(0, 8*65536)));
        if (ph == 7) begin
          lo3[a] = $urandom();
          hi3[a] = $urandom();
        end
      end
      set_box(lo3[0], lo3[1], lo3[2], hi3[0], hi3[1], hi3[2]);
      for (int i = 0; i < N_RANDOM / 8; i++) begin
        r = rand_ray();
        send_ray(r, 1'b0, none, ph != 7 || i < N_RANDOM / 8 - N_QUIET);
        // sender holds until the results are all in
        if (ph == 3 && i == 100) begin
          end_burst();
          while (hits_pending.size() != 0) @(posedge clk);
        end
        if (ph == 7 && i == N_RANDOM / 8 - N_QUIET) rx_quiet = 1'b1;
      end
      end_burst();
    end

    while (hits_pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (n_fail == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
